// ===== hw/rtl/vps_pkg.sv =====
`default_nettype none

package vps_pkg;

  // lane pipeline depth, output register not counted
  localparam int unsigned NSTG = 7;

  // floor(x / 10) = (x * DIV10_MUL) >> DIV10_SHIFT for any x below 2^32
  localparam logic [31:0] DIV10_MUL   = 32'hCCCC_CCCD;
  localparam int unsigned DIV10_SHIFT = 35;

  // 1.0 in Q8.24, wide enough for the wall compares
  localparam logic signed [35:0] Q_ONE = 36'sd16777216;

  localparam logic [15:0] DAMP_RESET = 16'd10240;

  typedef enum logic [1:0] {
    REG_GRAV_X    = 2'd0,
    REG_GRAV_Y    = 2'd1,
    REG_TIME_STEP = 2'd2,
    REG_DAMPING   = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic signed [31:0] grav_x;
    logic signed [31:0] grav_y;
    logic        [15:0] damping;
    logic        [31:0] dt2;
  } cfg_t;

endpackage

`default_nettype wire

// ===== hw/rtl/vps_regs.sv =====
`default_nettype none

module vps_regs (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output vps_pkg::cfg_t      cfg
);
  import vps_pkg::*;

  logic signed [31:0] grav_x;
  logic signed [31:0] grav_y;
  logic        [31:0] time_step;
  logic        [15:0] damping;
  logic        [31:0] dt2;
  logic        [63:0] ts_sq;
  logic               wr;
  reg_idx_t           idx;

  assign pready = 1'b1;
  assign wr     = psel & penable & pwrite;
  assign idx    = reg_idx_t'(paddr[3:2]);
  assign ts_sq  = 64'(time_step) * 64'(time_step);

  always_ff @(posedge clk) begin
    if (rst) begin
      grav_x    <= '0;
      grav_y    <= '0;
      time_step <= '0;
      damping   <= DAMP_RESET;
      dt2       <= '0;
    end else begin
      // dt squared follows the time step in the next cycle
      dt2 <= ts_sq[63:32];
      if (wr) begin
        unique case (idx)
          REG_GRAV_X:    grav_x    <= pwdata;
          REG_GRAV_Y:    grav_y    <= pwdata;
          REG_TIME_STEP: time_step <= pwdata;
          REG_DAMPING:   damping   <= pwdata[15:0];
          default:       ;
        endcase
      end
    end
  end

  always_comb begin
    unique case (idx)
      REG_GRAV_X:    prdata = grav_x;
      REG_GRAV_Y:    prdata = grav_y;
      REG_TIME_STEP: prdata = time_step;
      REG_DAMPING:   prdata = {16'd0, damping};
      default:       prdata = '0;
    endcase
  end

  assign cfg.grav_x  = grav_x;
  assign cfg.grav_y  = grav_y;
  assign cfg.damping = damping;
  assign cfg.dt2     = dt2;

endmodule

`default_nettype wire

// ===== hw/rtl/vps_lane.sv =====
`default_nettype none

module vps_lane (
  input  logic                       clk,
  input  logic [vps_pkg::NSTG-1:0]   stage_en,
  input  logic signed [31:0]         pos,
  input  logic signed [31:0]         last,
  input  logic signed [31:0]         accel,
  input  logic signed [31:0]         grav,
  input  logic        [15:0]         damping,
  input  logic        [31:0]         dt2,
  input  logic        [24:0]         lim,
  input  logic        [24:0]         rad,
  output logic signed [31:0]         new_pos,
  output logic signed [31:0]         prev_pos
);
  import vps_pkg::*;

  function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
    if (v > 36'sd2147483647)       sat32 = 32'sh7FFF_FFFF;
    else if (v < -36'sd2147483648) sat32 = 32'sh8000_0000;
    else                           sat32 = v[31:0];
  endfunction

  // stage 1: acceleration plus gravity, last move
  logic signed [31:0] acc1, pos1;
  logic signed [32:0] mv1;
  logic signed [32:0] acc_sum;
  // stage 2: damping product
  logic signed [49:0] dmp2;
  logic signed [31:0] acc2, pos2;
  logic signed [32:0] mv2;
  // stage 3: damped term, magnitude and sign
  logic        [42:0] mag3;
  logic               neg3;
  logic signed [32:0] mv3;
  logic signed [31:0] pos3;
  logic        [24:0] lim3, rad3;
  logic signed [49:0] dmp_adj;
  logic signed [41:0] q;
  logic signed [42:0] t;
  // stage 4: partial products against dt squared
  logic        [58:0] ph4, pl4;
  logic               neg4;
  logic signed [32:0] mv4;
  logic signed [31:0] pos4;
  logic        [24:0] lim4, rad4;
  // stage 5: signed step
  logic signed [44:0] step5;
  logic signed [32:0] mv5;
  logic signed [31:0] pos5;
  logic        [24:0] lim5, rad5;
  logic        [59:0] rsum;
  // stage 6: limited displacement
  logic signed [25:0] d6;
  logic signed [31:0] pos6;
  logic        [24:0] rad6;
  logic signed [45:0] d, limw;
  // stage 7: walls and saturation
  logic signed [31:0] new7, pos7;
  logic signed [35:0] p, p_lo, p_hi, radw, pw;

  assign acc_sum = {accel[31], accel} + {grav[31], grav};

  always_ff @(posedge clk) begin
    if (stage_en[0]) begin
      acc1 <= sat32({{3{acc_sum[32]}}, acc_sum});
      mv1  <= {pos[31], pos} - {last[31], last};
      pos1 <= pos;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_en[1]) begin
      dmp2 <= 50'(mv1) * $signed({1'b0, damping});
      acc2 <= acc1;
      mv2  <= mv1;
      pos2 <= pos1;
    end
  end

  // division by 256 rounds toward zero
  always_comb begin
    dmp_adj = dmp2 + (dmp2[49] ? 50'sd255 : 50'sd0);
    q       = dmp_adj[49:8];
    t       = {{11{acc2[31]}}, acc2} - {q[41], q};
  end

  always_ff @(posedge clk) begin
    if (stage_en[2]) begin
      mag3 <= t[42] ? 43'(-t) : 43'(t);
      neg3 <= t[42];
      mv3  <= mv2;
      pos3 <= pos2;
      lim3 <= lim;
      rad3 <= rad;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_en[3]) begin
      ph4  <= 59'(mag3) * 59'(dt2[31:16]);
      pl4  <= 59'(mag3) * 59'(dt2[15:0]);
      neg4 <= neg3;
      mv4  <= mv3;
      pos4 <= pos3;
      lim4 <= lim3;
      rad4 <= rad3;
    end
  end

  assign rsum = 60'(ph4) + 60'(pl4[58:16]);

  always_ff @(posedge clk) begin
    if (stage_en[4]) begin
      step5 <= neg4 ? -$signed({1'b0, rsum[59:16]}) : $signed({1'b0, rsum[59:16]});
      mv5   <= mv4;
      pos5  <= pos4;
      lim5  <= lim4;
      rad5  <= rad4;
    end
  end

  // speed limit on the displacement
  always_comb begin
    d    = {{13{mv5[32]}}, mv5} + {step5[44], step5};
    limw = $signed({21'd0, lim5});
    if (d > limw)       d = limw;
    else if (d < -limw) d = -limw;
  end

  always_ff @(posedge clk) begin
    if (stage_en[5]) begin
      d6   <= d[25:0];
      pos6 <= pos5;
      rad6 <= rad5;
    end
  end

  // push back inside the box walls
  always_comb begin
    radw = $signed({11'd0, rad6});
    p    = {{4{pos6[31]}}, pos6} + {{10{d6[25]}}, d6};
    p_lo = p - radw;
    p_hi = p + radw;
    if (p_lo < -Q_ONE)     pw = radw - Q_ONE;
    else if (p_hi > Q_ONE) pw = Q_ONE - radw;
    else                   pw = p;
  end

  always_ff @(posedge clk) begin
    if (stage_en[6]) begin
      new7 <= sat32(pw);
      pos7 <= pos6;
    end
  end

  assign new_pos  = new7;
  assign prev_pos = pos7;

endmodule

`default_nettype wire

// ===== hw/rtl/verlet_particle_step.sv =====
// verlet_particle_step: one damped position-verlet step per particle record
//
// input channel (in_valid / in_ready) carries one particle record per
// transaction: id, position, previous position, pending acceleration,
// radius and collided flag. output channel (out_valid / out_ready) returns
// one transaction per record: id, new position and the old position as the
// new previous position. results leave in input order.
//
// throughput: one record per cycle unless out_ready stalls the output. x
// and y go down two identical lanes, each a 7-stage pipeline, and a shared
// output register merges them before out_valid rises.
//
// stalls: every stage holds when the one after it is full and blocked, so
// while the output waits on out_ready, upstream bubbles still fill and
// in_ready stays high until the whole pipe is full.
//
// reset (synchronous, active high) empties the pipe and loads the register
// defaults; configuration goes over the apb port while the block is idle.
// dt squared is taken from time_step in the cycle after the write.

`default_nettype none

module verlet_particle_step (
  input  logic               clk,
  input  logic               rst,
  // configuration
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  // particle records in
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [11:0]        particle_id,
  input  logic signed [31:0] pos_x,
  input  logic signed [31:0] pos_y,
  input  logic signed [31:0] last_x,
  input  logic signed [31:0] last_y,
  input  logic signed [31:0] accel_x,
  input  logic signed [31:0] accel_y,
  input  logic [24:0]        radius,
  input  logic               collided,
  // results out
  output logic               out_valid,
  input  logic               out_ready,
  output logic [11:0]        out_id,
  output logic signed [31:0] new_x,
  output logic signed [31:0] new_y,
  output logic signed [31:0] prev_x,
  output logic signed [31:0] prev_y
);
  import vps_pkg::*;

  cfg_t               cfg;
  logic [NSTG-1:0]    stage_en;
  logic [NSTG-1:0]    vld;
  logic               out_en;
  logic [11:0]        id_q [NSTG];
  logic [24:0]        rad1, rad2, lim2;
  logic               coll1;
  logic [56:0]        prod1;
  logic signed [31:0] lane_new_x, lane_new_y, lane_prev_x, lane_prev_y;

  vps_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // a stage may load when it is empty or the next one moves
  assign out_en = !out_valid || out_ready;

  always_comb begin
    stage_en[NSTG-1] = !vld[NSTG-1] || out_en;
    for (int k = NSTG - 2; k >= 0; k--) begin
      stage_en[k] = !vld[k] || stage_en[k+1];
    end
  end

  assign in_ready = stage_en[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (stage_en[0]) vld[0] <= in_valid;
      for (int k = 1; k < NSTG; k++) begin
        if (stage_en[k]) vld[k] <= vld[k-1];
      end
      if (out_en) out_valid <= vld[NSTG-1];
    end
  end

  // id travels alongside the lanes
  always_ff @(posedge clk) begin
    if (stage_en[0]) id_q[0] <= particle_id;
    for (int k = 1; k < NSTG; k++) begin
      if (stage_en[k]) id_q[k] <= id_q[k-1];
    end
  end

  // speed limit shared by both lanes: radius, or radius/10 after a collision
  always_ff @(posedge clk) begin
    if (stage_en[0]) begin
      prod1 <= 57'(radius) * 57'(DIV10_MUL);
      rad1  <= radius;
      coll1 <= collided;
    end
    if (stage_en[1]) begin
      lim2 <= coll1 ? 25'(prod1[56:DIV10_SHIFT]) : rad1;
      rad2 <= rad1;
    end
  end

  vps_lane u_lane_x (
    .clk      (clk),
    .stage_en (stage_en),
    .pos      (pos_x),
    .last     (last_x),
    .accel    (accel_x),
    .grav     (cfg.grav_x),
    .damping  (cfg.damping),
    .dt2      (cfg.dt2),
    .lim      (lim2),
    .rad      (rad2),
    .new_pos  (lane_new_x),
    .prev_pos (lane_prev_x)
  );

  vps_lane u_lane_y (
    .clk      (clk),
    .stage_en (stage_en),
    .pos      (pos_y),
    .last     (last_y),
    .accel    (accel_y),
    .grav     (cfg.grav_y),
    .damping  (cfg.damping),
    .dt2      (cfg.dt2),
    .lim      (lim2),
    .rad      (rad2),
    .new_pos  (lane_new_y),
    .prev_pos (lane_prev_y)
  );

  // merge: both lanes and the id into one result transaction
  always_ff @(posedge clk) begin
    if (out_en) begin
      out_id <= id_q[NSTG-1];
      new_x  <= lane_new_x;
      new_y  <= lane_new_y;
      prev_x <= lane_prev_x;
      prev_y <= lane_prev_y;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/vps_checker.sv =====
`default_nettype none

module vps_checker (
  input logic               clk,
  input logic               rst,
  input logic               pready,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [31:0] new_x,
  input logic signed [31:0] new_y
);

  // reset empties the output
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("out_valid set after reset");

  // with the output empty the whole pipe can move, so input is open
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("in_ready low with empty output");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(new_x) && $stable(new_y))
    else $error("stalled result dropped or changed");

  a_pready: assert property (@(posedge clk) disable iff (rst) pready)
    else $error("pready low");

endmodule

bind verlet_particle_step vps_checker u_vps_checker (.*);

`default_nettype wire

// ===== sim/verlet_particle_step_tb.sv =====
`timescale 1ns / 100ps

module verlet_particle_step_tb;
  import vps_pkg::*;

  // 1.0 in q8.24
  localparam int Q1 = 1 << 24;
  localparam longint Q1_L = 64'sd16777216;

  // one particle record as it goes over the input channel
  typedef struct packed {
    logic [11:0]        id;
    logic signed [31:0] pos_x, pos_y;
    logic signed [31:0] last_x, last_y;
    logic signed [31:0] accel_x, accel_y;
    logic [24:0]        radius;
    logic               collided;
  } particle_t;

  // one result transaction
  typedef struct packed {
    logic [11:0] id;
    logic [31:0] new_x, new_y;
    logic [31:0] prev_x, prev_y;
  } step_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  // apb side
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // record and result channels
  logic         in_valid = 1'b0;
  logic         in_ready;
  particle_t    on_wire = '0;
  logic         out_valid;
  logic         out_ready = 1'b0;
  logic [11:0]  out_id;
  logic [31:0]  new_x, new_y, prev_x, prev_y;

  // local copy of the register file, only changed while the block is idle
  logic signed [31:0] cfg_grav_x = '0;
  logic signed [31:0] cfg_grav_y = '0;
  logic [31:0]        cfg_dt = '0;
  logic [15:0]        cfg_damp = DAMP_RESET;

  particle_t    particles_to_send[$];
  step_result_t predicted_positions[$];
  step_result_t predicted_head;
  int           records_queued = 0;
  int           positions_seen = 0;
  int           error_count = 0;
  int           send_idle_pct = 0;
  int           recv_stall_pct = 0;

  verlet_particle_step dut (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .particle_id (on_wire.id),
    .pos_x       (on_wire.pos_x),
    .pos_y       (on_wire.pos_y),
    .last_x      (on_wire.last_x),
    .last_y      (on_wire.last_y),
    .accel_x     (on_wire.accel_x),
    .accel_y     (on_wire.accel_y),
    .radius      (on_wire.radius),
    .collided    (on_wire.collided),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_id      (out_id),
    .new_x       (new_x),
    .new_y       (new_y),
    .prev_x      (prev_x),
    .prev_y      (prev_y)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  // saturate to signed 32 bits
  function automatic longint clip32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // trunc(t * u / 2^32) toward zero, done in two 16-bit halves of u
  function automatic longint scale_q32(longint t, logic [31:0] u);
    logic [63:0] mag;
    logic [63:0] r;
    logic        neg;
    neg = (t < 0);
    mag = neg ? -t : t;
    r = ((mag * {48'b0, u[31:16]}) + ((mag * {48'b0, u[15:0]}) >> 16)) >> 16;
    return neg ? -longint'(r) : longint'(r);
  endfunction

  // one axis: gravity, damped verlet step, speed limit, then the walls
  function automatic logic [31:0] axis_update(
    input logic signed [31:0] pos, last, accel, grav,
    input logic [31:0]        dt2,
    input longint             lim, rad
  );
    longint acc, mv, t, d, p;
    acc = clip32(longint'(accel) + longint'(grav));
    mv  = longint'(pos) - longint'(last);
    // damping is q8.8, the product is cut back toward zero
    t   = acc - (mv * longint'({48'b0, cfg_damp})) / 256;
    d   = mv + scale_q32(t, dt2);
    if (d > lim) d = lim;
    if (d < -lim) d = -lim;
    p = longint'(pos) + d;
    if (p - rad < -Q1_L)
      p = -Q1_L + rad;
    else if (p + rad > Q1_L)
      p = Q1_L - rad;
    p = clip32(p);
    return p[31:0];
  endfunction

  function automatic step_result_t verlet_predict(particle_t r);
    step_result_t o;
    logic [63:0]  dt_sq;
    longint       rad, lim;
    dt_sq = ({32'b0, cfg_dt} * {32'b0, cfg_dt}) >> 32;
    rad = longint'({39'b0, r.radius});
    // collided particles may only move a tenth of their radius
    lim = r.collided ? rad / 10 : rad;
    o.id     = r.id;
    o.new_x  = axis_update(r.pos_x, r.last_x, r.accel_x, cfg_grav_x, dt_sq[31:0], lim, rad);
    o.new_y  = axis_update(r.pos_y, r.last_y, r.accel_y, cfg_grav_y, dt_sq[31:0], lim, rad);
    o.prev_x = r.pos_x;
    o.prev_y = r.pos_y;
    return o;
  endfunction

  // ---------------------------------------------------------------------------
  // driver: holds each record until its transaction completes
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      // record accepted at this edge, work out what should come back
      if (in_valid && in_ready)
        predicted_positions.push_back(verlet_predict(on_wire));
      // the wire is free when nothing was offered or the offer just went through
      if (!in_valid || in_ready) begin
        if (particles_to_send.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          on_wire  <= particles_to_send.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: compares each result transaction with the oldest prediction
  // ---------------------------------------------------------------------------
  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      error_count++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        positions_seen++;
        if (predicted_positions.size() == 0) begin
          $display("%0t: result transaction with none pending, id %h", $time, out_id);
          error_count++;
        end else begin
          predicted_head = predicted_positions.pop_front();
          check_field("out_id", {20'b0, predicted_head.id}, {20'b0, out_id});
          check_field("new_x", predicted_head.new_x, new_x);
          check_field("new_y", predicted_head.new_y, new_y);
          check_field("prev_x", predicted_head.prev_x, prev_x);
          check_field("prev_y", predicted_head.prev_y, prev_y);
        end
      end
      out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------

  // apb write: setup cycle, then access cycle, register loads at the edge that ends the access cycle
  task automatic write_reg(reg_idx_t idx, logic [31:0] val);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_GRAV_X:    cfg_grav_x = val;
      REG_GRAV_Y:    cfg_grav_y = val;
      REG_TIME_STEP: cfg_dt = val;
      REG_DAMPING:   cfg_damp = val[15:0];
      default: ;
    endcase
  endtask

  // damping last, so dt squared has settled before the next record
  task automatic set_config(logic [31:0] gx, logic [31:0] gy, logic [31:0] dt,
                            logic [15:0] damp);
    write_reg(REG_GRAV_X, gx);
    write_reg(REG_GRAV_Y, gy);
    write_reg(REG_TIME_STEP, dt);
    write_reg(REG_DAMPING, {16'b0, damp});
  endtask

  task automatic queue_record(particle_t r);
    particles_to_send.push_back(r);
    records_queued++;
  endtask

  // wait until every queued record has come back
  task automatic drain();
    while (positions_seen < records_queued)
      @(posedge clk);
  endtask

  function automatic particle_t mk_record(int id, int px, int py, int lx, int ly,
                                          int ax, int ay, int rad, bit col);
    particle_t r;
    r.id = 12'(id);
    r.pos_x = px;
    r.pos_y = py;
    r.last_x = lx;
    r.last_y = ly;
    r.accel_x = ax;
    r.accel_y = ay;
    r.radius = 25'(rad);
    r.collided = col;
    return r;
  endfunction

  // signed value in [-lim, lim]
  function automatic logic [31:0] srand(int unsigned lim);
    logic [31:0] r;
    r = $urandom_range(0, 2 * lim);
    return r - lim;
  endfunction

  // mostly particles near the box with plausible motion, some raw noise
  function automatic particle_t rand_record();
    particle_t   r;
    int unsigned mv_span;
    int unsigned acc_sel;
    r.id = 12'($urandom_range(0, 4095));
    r.collided = 1'($urandom_range(0, 1));
    if ($urandom_range(0, 99) < 20) begin
      r.pos_x = $urandom;
      r.pos_y = $urandom;
      r.last_x = $urandom;
      r.last_y = $urandom;
      r.accel_x = $urandom;
      r.accel_y = $urandom;
      r.radius = 25'($urandom_range(0, (1 << 25) - 1));
    end else begin
      case ($urandom_range(0, 9))
        7, 8:    r.radius = 25'($urandom_range(0, 1 << 24));
        9:       r.radius = 25'($urandom_range(0, (1 << 25) - 1));
        default: r.radius = 25'($urandom_range(0, 1 << 21));
      endcase
      mv_span = 1 << (16 + 3 * $urandom_range(0, 3));
      r.pos_x = srand(21_000_000);
      r.pos_y = srand(21_000_000);
      r.last_x = r.pos_x - srand(mv_span);
      r.last_y = r.pos_y - srand(mv_span);
      acc_sel = $urandom_range(0, 3);
      if (acc_sel == 3) begin
        r.accel_x = $urandom;
        r.accel_y = $urandom;
      end else begin
        r.accel_x = srand(1 << (20 + 4 * acc_sel));
        r.accel_y = srand(1 << (20 + 4 * acc_sel));
      end
    end
    return r;
  endfunction

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed, register defaults: dt is zero so only limit and walls act
    queue_record(mk_record(0, 0, 0, 0, 0, 0, 0, 0, 0));
    queue_record(mk_record(12'hFFF, 32'h7FFFFFFF, 32'h80000000, 32'h80000000, 32'h7FFFFFFF,
                           32'h7FFFFFFF, 32'h80000000, 25'h1FFFFFF, 1));
    queue_record(mk_record(1, 32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000,
                           32'h80000000, 32'h7FFFFFFF, 0, 0));
    // x runs into the lower wall, y into the upper wall
    queue_record(mk_record(2, -Q1 / 100 * 99, Q1 / 100 * 99, -Q1 / 100 * 99 + Q1 / 25,
                           Q1 / 100 * 99 - Q1 / 25, 0, 0, Q1 / 20, 0));
    // speed limit at full radius, then at a tenth with an odd radius
    queue_record(mk_record(3, 0, 0, -Q1 / 2, Q1 / 2, 0, 0, Q1 / 100, 0));
    queue_record(mk_record(4, 0, 0, -Q1 / 2, Q1 / 2, 0, 0, Q1 / 100 + 7, 1));
    // collided with a radius under ten: no motion allowed at all
    queue_record(mk_record(5, Q1 / 4, -Q1 / 4, Q1 / 4 - 5, -Q1 / 4 + 5, 0, 0, 9, 1));
    // radius of exactly one, and above one
    queue_record(mk_record(6, Q1 / 4, -Q1 / 4, 0, 0, 0, 0, Q1, 0));
    queue_record(mk_record(7, Q1 / 4, -Q1 / 4, 0, 0, 0, 0, Q1, 1));
    queue_record(mk_record(8, 0, Q1 / 8, Q1 / 8, 0, 0, 0, 25'h1FFFFFF, 0));
    // free motion, nothing clamps
    queue_record(mk_record(9, Q1 / 10, -Q1 / 10, Q1 / 10 - 1000, -Q1 / 10 + 1000,
                           Q1, -Q1, Q1 / 20, 0));
    // resting exactly on both walls
    queue_record(mk_record(10, -Q1 + Q1 / 20, Q1 - Q1 / 20, -Q1 + Q1 / 20, Q1 - Q1 / 20,
                           0, 0, Q1 / 20, 0));
    drain();

    // directed, largest gravity, dt and damping: acceleration sum saturates
    set_config(32'h7FFFFFFF, 32'h80000000, 32'hFFFFFFFF, 16'hFFFF);
    queue_record(mk_record(11, 0, 0, 0, 0, 32'h7FFFFFFF, 32'h80000000, Q1 / 50, 0));
    queue_record(mk_record(12, 0, 0, 0, 0, 32'h80000000, 32'h7FFFFFFF, Q1 / 50, 1));
    queue_record(mk_record(13, Q1 / 2, -Q1 / 2, -Q1 / 2, Q1 / 2, 0, 0, Q1, 0));
    queue_record(mk_record(12'hFFF, 32'h7FFFFFFF, 32'h80000000, 32'h80000000, 32'h7FFFFFFF,
                           32'h7FFFFFFF, 32'h80000000, 25'h1FFFFFF, 1));
    queue_record(mk_record(14, 32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000,
                           32'h80000000, 32'h7FFFFFFF, 0, 0));
    drain();

    // directed, smallest gravity, zero damping, dt squared rounds to zero
    set_config(32'h80000000, 32'h7FFFFFFF, 32'h00000001, 16'h0000);
    queue_record(mk_record(15, 0, 0, Q1 / 64, -Q1 / 64, 32'h80000000, 32'h7FFFFFFF,
                           Q1 / 10, 0));
    queue_record(mk_record(16, Q1 / 3, -Q1 / 3, Q1 / 3 + 77, -Q1 / 3 - 77, -Q1, Q1,
                           Q1 / 30, 1));
    drain();

    // random phases, each with its own register setting and idle pattern
    for (int p = 0; p < 8; p++) begin
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 75; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 75; end
        default: begin send_idle_pct = 32; recv_stall_pct = 32; end
      endcase
      case (p)
        // earth-like gravity along -y, sixty steps a second, default damping
        0: set_config(32'h0, -32'sd164416717, 32'd71582788, DAMP_RESET);
        1: set_config(32'h7FFFFFFF, 32'h80000000, 32'hFFFFFFFF, 16'hFFFF);
        2: set_config(32'h80000000, 32'h7FFFFFFF, 32'h80000000, 16'h0000);
        default: begin
          if ($urandom_range(0, 3) == 0)
            set_config($urandom, $urandom, $urandom, 16'($urandom_range(0, 65535)));
          else
            set_config(srand(1 << 28), srand(1 << 28), $urandom_range(0, 32'h0800_0000),
                       16'($urandom_range(0, 65535)));
        end
      endcase
      for (int i = 0; i < 235; i++)
        queue_record(rand_record());
      drain();
    end

    // let any stray result show up before the final verdict
    repeat (NSTG + 8) @(posedge clk);
    if (predicted_positions.size() != 0) begin
      $display("%0t: %0d result transactions never arrived", $time,
               predicted_positions.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // hang guard, far beyond the slowest legal run
  initial begin
    #(5_000_000);
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
